/* hw/rtl/lpg_pkg.sv */
// Package for the line point generator: types, constants and register codes.
// Shared by lpg_front, lpg_fifo, lpg_back and line_point_generator.
// Depends on nothing.
package lpg_pkg;

    localparam int LPG_SIDE   = 64;
    localparam int COORD_W    = 6;
    localparam int LPG_QDEPTH = 2;
    localparam int SIZE_W     = 7;
    localparam int PEN_W      = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [PEN_W-1:0]  PEN_RESET    = 8'd42;

    typedef logic [COORD_W-1:0] coord_t;

    // One classified line command as it waits in the queue.
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t adx;
        coord_t ady;
        coord_t n;
        logic   x_neg;
        logic   y_neg;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    typedef enum logic [1:0] {
        REG_CANVAS_WIDTH  = 2'd0,
        REG_CANVAS_HEIGHT = 2'd1,
        REG_PEN_CODE      = 2'd2
    } reg_index_t;

endpackage

/* hw/rtl/lpg_front.sv */
// Front part of the line point generator: accepts a command, clamps the
// endpoints and works out the step counts and directions.
// Depends on lpg_pkg.
module lpg_front #(
    parameter int SIDE = lpg_pkg::LPG_SIDE
) (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,  // start_x, start_y, end_x, end_y
    input  logic          q_full,
    output logic          q_push,
    output lpg_pkg::cmd_t q_cmd
);
    import lpg_pkg::*;

    localparam coord_t MAX_COORD = coord_t'(SIDE - 1);

    coord_t sx, sy, ex, ey;
    coord_t adx, ady;

    function automatic coord_t clamp(input coord_t v);
        clamp = (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    always_comb begin
        sx  = clamp(s_tdata[5:0]);
        sy  = clamp(s_tdata[11:6]);
        ex  = clamp(s_tdata[17:12]);
        ey  = clamp(s_tdata[23:18]);
        adx = (ex >= sx) ? (ex - sx) : (sx - ex);
        ady = (ey >= sy) ? (ey - sy) : (sy - ey);

        q_cmd.sx    = sx;
        q_cmd.sy    = sy;
        q_cmd.adx   = adx;
        q_cmd.ady   = ady;
        q_cmd.n     = (adx > ady) ? adx : ady;
        q_cmd.x_neg = (ex < sx);
        q_cmd.y_neg = (ey < sy);
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

/* hw/rtl/lpg_fifo.sv */
// Short command queue between the front and the back part.
// Depends on lpg_pkg.
module lpg_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lpg_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          pop,
    output lpg_pkg::cmd_t rd_cmd,
    output logic          empty
);
    import lpg_pkg::*;

    localparam int PTR_W = (LPG_QDEPTH > 1) ? $clog2(LPG_QDEPTH) : 1;
    localparam int CNT_W = $clog2(LPG_QDEPTH + 1);

    cmd_t             mem_reg [LPG_QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(LPG_QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign full   = (count_reg == CNT_W'(LPG_QDEPTH));
    assign empty  = (count_reg == '0);

endmodule

/* hw/rtl/lpg_back.sv */
// Back part of the line point generator: steps through the points of one
// command with remainder accumulators and drives the registered output.
// Depends on lpg_pkg.
module lpg_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lpg_pkg::cmd_t                q_cmd,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic [lpg_pkg::SIZE_W-1:0]   canvas_width,
    input  logic [lpg_pkg::SIZE_W-1:0]   canvas_height,
    input  logic [lpg_pkg::PEN_W-1:0]    pen_code,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,  // point_x, point_y, color, zero pad
    output logic [0:0]                   m_tuser,  // inside_res
    output logic                         m_tlast
);
    import lpg_pkg::*;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    coord_t      x_reg, x_next;
    coord_t      y_reg, y_next;
    coord_t      accx_reg, accx_next;
    coord_t      accy_reg, accy_next;
    coord_t      cnt_reg;
    logic        advance;
    logic        is_last;

    logic               out_valid_reg;
    coord_t             out_x_reg, out_y_reg;
    logic               out_inside_reg, out_last_reg;
    logic [PEN_W-1:0]   out_color_reg;

    logic [COORD_W:0]   sum_x, sum_y;
    logic               wrap_x, wrap_y;

    assign is_last = (cnt_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop   = 1'b0;
        advance = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop   = !q_empty;
            ST_RUN:  advance = !out_valid_reg || m_tready;
            default: begin
                q_pop   = 1'b0;
                advance = 1'b0;
            end
        endcase
    end

    // The offset along each axis is floor(i*d/n); the accumulator keeps the
    // remainder, and since d never exceeds n one subtraction suffices.
    always_comb begin
        sum_x  = {1'b0, accx_reg} + {1'b0, cmd_reg.adx};
        sum_y  = {1'b0, accy_reg} + {1'b0, cmd_reg.ady};
        wrap_x = (sum_x >= {1'b0, cmd_reg.n});
        wrap_y = (sum_y >= {1'b0, cmd_reg.n});
        accx_next = wrap_x ? COORD_W'(sum_x - {1'b0, cmd_reg.n}) : sum_x[COORD_W-1:0];
        accy_next = wrap_y ? COORD_W'(sum_y - {1'b0, cmd_reg.n}) : sum_y[COORD_W-1:0];
        x_next = x_reg;
        y_next = y_reg;
        if (wrap_x) begin
            x_next = cmd_reg.x_neg ? x_reg - 1'b1 : x_reg + 1'b1;
        end
        if (wrap_y) begin
            y_next = cmd_reg.y_neg ? y_reg - 1'b1 : y_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg  <= q_cmd;
            x_reg    <= q_cmd.sx;
            y_reg    <= q_cmd.sy;
            accx_reg <= '0;
            accy_reg <= '0;
            cnt_reg  <= q_cmd.n;
        end else if (advance && !is_last) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            accx_reg <= accx_next;
            accy_reg <= accy_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
        if (advance) begin
            out_x_reg      <= x_reg;
            out_y_reg      <= y_reg;
            out_inside_reg <= ({1'b0, x_reg} < canvas_width) &&
                              ({1'b0, y_reg} < canvas_height);
            out_color_reg  <= pen_code;
            out_last_reg   <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_color_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_inside_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/line_point_generator.sv */
// Top level of the line point generator: configuration registers, front part,
// command queue and back part. Depends on lpg_pkg, lpg_front, lpg_fifo, lpg_back.
//
//   Channel  Ports                              Carries
//   input    s_tvalid s_tready s_tdata          one line command
//   output   m_tvalid m_tready m_tdata m_tuser  one point, m_tlast on the final one
//   config   psel penable pwrite paddr pwdata   canvas_width, canvas_height, pen_code
//
// For a line of n+1 points the back part first loads the command from the
// queue, then the stepping unit gives one point per cycle unless m_tready stalls.
// The queue holds two commands, so the front can take two more while a line runs.
// Reset is synchronous and clears control state and the registers to defaults.
// A stall on m_tready holds the output register and the stepping unit.
module line_point_generator #(
    parameter int SIDE = lpg_pkg::LPG_SIDE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // start_x, start_y, end_x, end_y
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // point_x, point_y, color, zero pad
    output logic [0:0]                  m_tuser,  // inside_res
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [lpg_pkg::DATA_W-1:0]  pwdata,
    output logic [lpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lpg_pkg::*;

    logic [SIZE_W-1:0] canvas_width_reg;
    logic [SIZE_W-1:0] canvas_height_reg;
    logic [PEN_W-1:0]  pen_code_reg;
    logic              cfg_write;
    logic [1:0]        cfg_index;

    cmd_t front_cmd, back_cmd;
    logic q_push, q_pop, q_full, q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= WIDTH_RESET;
            canvas_height_reg <= HEIGHT_RESET;
            pen_code_reg      <= PEN_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= pwdata[SIZE_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[SIZE_W-1:0];
                REG_PEN_CODE:      pen_code_reg      <= pwdata[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_CANVAS_WIDTH:  prdata = DATA_W'(canvas_width_reg);
            REG_CANVAS_HEIGHT: prdata = DATA_W'(canvas_height_reg);
            REG_PEN_CODE:      prdata = DATA_W'(pen_code_reg);
            default:           prdata = '0;
        endcase
    end

    lpg_front #(
        .SIDE (SIDE)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    lpg_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_cmd  (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_cmd  (back_cmd),
        .empty   (q_empty)
    );

    lpg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_cmd         (back_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .pen_code      (pen_code_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

`ifndef SYNTHESIS
    localparam coord_t MAX_POINT = coord_t'(SIDE - 1);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_pop_needs_command: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("back part took a command from an empty queue");

    a_point_on_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= MAX_POINT) && (m_tdata[11:6] <= MAX_POINT))
        else $error("point beyond the grid");
`endif

endmodule
